// ===== rtl/core/sync_framed_packet_crc_checker_assert.svh =====
// assertion macros for the sync framed packet crc checker
// used by the port checker; needs clk and rst_n in scope
`ifndef SYNC_FRAMED_PACKET_CRC_CHECKER_ASSERT_SVH
`define SYNC_FRAMED_PACKET_CRC_CHECKER_ASSERT_SVH

// same-cycle implication
`define SFPCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFPCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sfpcc_pkg.sv =====
// shared types, constants and crc step for the sync framed packet crc checker
// no dependencies
`default_nettype none

package sfpcc_pkg;

    localparam int unsigned PAYLOAD_LEN = 7;
    localparam int unsigned CRC_SPAN    = 5;
    localparam int unsigned STORE_DEPTH = PAYLOAD_LEN - 1;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    // configuration register indexes
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    localparam logic [2:0] LAST_COUNT = 3'(PAYLOAD_LEN - 1);
    localparam logic [2:0] CRC_COUNT  = 3'(CRC_SPAN);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_GOT_FIRST,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic [7:0]  tag_byte;
        logic [31:0] value_word;
        logic [15:0] received_crc;
        logic        crc_ok;
    } result_t;

    // one byte of crc-16/ccitt-false, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfpcc_in_stage.sv =====
// input register for received bytes
// depends on sfpcc_pkg
`default_nettype none

module sfpcc_in_stage
    import sfpcc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output logic            byte_vld,
    output logic [7:0]      byte_data
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] data_reg;

    assign in_ready  = !vld_reg || advance;
    assign byte_vld  = vld_reg;
    assign byte_data = data_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
            vld_next = 1'b1;
        else if (advance)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= rx_byte;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfpcc_parser.sv =====
// sync hunt state machine, payload store and running crc
// depends on sfpcc_pkg
`default_nettype none

module sfpcc_parser
    import sfpcc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_vld,
    input  wire logic [7:0] byte_data,
    input  wire logic [7:0] sync_first,
    input  wire logic [7:0] sync_second,
    input  wire logic       out_free,
    output logic            advance,
    output logic            res_fire,
    output result_t         res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  store_reg [STORE_DEPTH];

    logic        is_final;
    logic        store_we;
    logic [15:0] crc_upd;

    assign crc_upd  = crc_byte(crc_reg, byte_data);
    assign is_final = (phase_reg == PH_PAYLOAD) && (count_reg == LAST_COUNT);
    // only the last payload byte can wait on the output
    assign advance  = byte_vld && (!is_final || out_free);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        if (advance) begin
            case (phase_reg)
                PH_GOT_FIRST:
                begin
                    if (byte_data == sync_second) begin
                        phase_next = PH_PAYLOAD;
                        count_next = 3'd0;
                        crc_next   = CRC_INIT;
                    end else if (byte_data == sync_first) begin
                        phase_next = PH_GOT_FIRST;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (count_reg == LAST_COUNT) begin
                        phase_next = PH_HUNT;
                        count_next = 3'd0;
                        crc_next   = CRC_INIT;
                    end else begin
                        count_next = count_reg + 3'd1;
                        if (count_reg < CRC_COUNT)
                            crc_next = crc_upd;
                    end
                end
                default:
                begin
                    phase_next = (byte_data == sync_first) ? PH_GOT_FIRST : PH_HUNT;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        store_we             = advance && (phase_reg == PH_PAYLOAD) && !is_final;
        res_fire             = advance && is_final;
        res.tag_byte         = store_reg[0];
        res.value_word       = {store_reg[4], store_reg[3], store_reg[2], store_reg[1]};
        res.received_crc     = {byte_data, store_reg[5]};
        res.crc_ok           = (crc_reg == {byte_data, store_reg[5]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_HUNT;
            count_reg <= 3'd0;
            crc_reg   <= CRC_INIT;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[count_reg] <= byte_data;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfpcc_out_stage.sv =====
// result register with valid/ready toward the consumer
// depends on sfpcc_pkg
`default_nettype none

module sfpcc_out_stage
    import sfpcc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_fire,
    input  wire result_t res,
    output logic         out_free,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign out_free  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (res_fire)
            vld_next = 1'b1;
        else if (out_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
            res_reg <= res;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sync_framed_packet_crc_checker.sv =====
// top level: sync pair hunt, 7-byte payload capture, crc-16/ccitt-false check
// depends on sfpcc_pkg, sfpcc_in_stage, sfpcc_parser, sfpcc_out_stage
//
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    rx_byte
// out      out  out_valid / out_ready  tag_byte, value_word, received_crc, crc_ok
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// unless stalled, one byte per cycle, each parsed the cycle after its beat
// a result shows the cycle after the last payload byte is parsed
// in_ready drops only while a finished result waits and the next byte ends a frame
// reset clears handshake state, sync registers to aa/55 and the parser to hunting
// cfg_ready is always high
`default_nettype none

module sync_framed_packet_crc_checker
    import sfpcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       tag_byte,
    output logic [31:0]      value_word,
    output logic [15:0]      received_crc,
    output logic             crc_ok,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;

    logic       byte_vld;
    logic [7:0] byte_data;
    logic       advance;
    logic       out_free;
    logic       res_fire;
    result_t    res;
    result_t    out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:         sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    sfpcc_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .advance   (advance),
        .byte_vld  (byte_vld),
        .byte_data (byte_data)
    );

    sfpcc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_vld    (byte_vld),
        .byte_data   (byte_data),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .out_free    (out_free),
        .advance     (advance),
        .res_fire    (res_fire),
        .res         (res)
    );

    sfpcc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_fire  (res_fire),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign tag_byte     = out_res.tag_byte;
    assign value_word   = out_res.value_word;
    assign received_crc = out_res.received_crc;
    assign crc_ok       = out_res.crc_ok;

endmodule

`default_nettype wire

// ===== rtl/core/sfpcc_checker.sv =====
// port-level checker for the sync framed packet crc checker, bound to the top level
// depends on sync_framed_packet_crc_checker_assert.svh
`default_nettype none

`include "sync_framed_packet_crc_checker_assert.svh"

module sfpcc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  tag_byte,
    input  wire logic [31:0] value_word,
    input  wire logic [15:0] received_crc,
    input  wire logic        crc_ok,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic out_hold;
    logic in_beat;
    logic unused_ok;

    assign out_hold  = out_valid && !out_ready;
    assign in_beat   = in_valid && in_ready;
    assign unused_ok = ^{rx_byte, cfg_valid, cfg_index, cfg_data};

    // stalled result beat keeps its payload
    `SFPCC_ASSERT_NEXT(a_out_hold, out_hold,
        out_valid && $stable(tag_byte) && $stable(value_word) &&
        $stable(received_crc) && $stable(crc_ok), "result beat changed while stalled")

    // input backpressure comes only from a stalled result
    `SFPCC_ASSERT_NOW(a_in_stall, !in_ready, out_hold, "input stalled without output stall")

    // a fresh result follows an earlier byte beat
    `SFPCC_ASSERT_NOW(a_res_src, $rose(out_valid) && unused_ok == unused_ok,
        $past(in_beat, 2), "result without a preceding byte beat")

    // config port never stalls
    `SFPCC_ASSERT_NOW(a_cfg_rdy, 1'b1, cfg_ready, "config port not ready")

endmodule

bind sync_framed_packet_crc_checker sfpcc_checker u_sfpcc_checker (.*);

`default_nettype wire

// ===== dv/sync_framed_packet_crc_checker_tb.sv =====
// testbench for sync_framed_packet_crc_checker: byte stream stimulus, frame prediction
// and field-by-field checking of every result; depends on sfpcc_pkg and the block rtl
`timescale 1ns / 1ps

module sync_framed_packet_crc_checker_tb;
    import sfpcc_pkg::*;

    // tracks the sync hunt and payload capture, queues the frames that must come out
    class frame_scoreboard;
        logic [7:0]  sync_lead;
        logic [7:0]  sync_trail;
        phase_t      phase;
        int unsigned count;
        logic [7:0]  store [PAYLOAD_LEN];
        logic [15:0] crc;
        result_t     pending_frames [$];
        int          mismatches;

        function new();
            sync_lead  = SYNC_FIRST_RST;
            sync_trail = SYNC_SECOND_RST;
            phase      = PH_HUNT;
            count      = 0;
            crc        = CRC_INIT;
            mismatches = 0;
        endfunction

        // bit-serial crc-16/ccitt-false, msb of the byte first
        static function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            logic        fb;
            int          k;
            r = c;
            for (k = 7; k >= 0; k--)
            begin
                fb = r[15] ^ b[k];
                r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            end
            return r;
        endfunction

        function void set_reg(logic idx, logic [7:0] val);
            if (idx == REG_SYNC_FIRST)
                sync_lead = val;
            else
                sync_trail = val;
        endfunction

        function void absorb_byte(logic [7:0] b);
            result_t r;
            case (phase)
                PH_GOT_FIRST:
                begin
                    if (b == sync_trail)
                    begin
                        phase = PH_PAYLOAD;
                        count = 0;
                        crc   = CRC_INIT;
                    end
                    else if (b != sync_lead)
                        phase = PH_HUNT;
                end
                PH_PAYLOAD:
                begin
                    store[count] = b;
                    if (count < CRC_SPAN)
                        crc = crc_update(crc, b);
                    count++;
                    if (count == PAYLOAD_LEN)
                    begin
                        r.tag_byte     = store[0];
                        r.value_word   = {store[4], store[3], store[2], store[1]};
                        r.received_crc = {store[6], store[5]};
                        r.crc_ok       = (crc == r.received_crc);
                        pending_frames.push_back(r);
                        phase = PH_HUNT;
                        count = 0;
                        crc   = CRC_INIT;
                    end
                end
                default:
                    phase = (b == sync_lead) ? PH_GOT_FIRST : PH_HUNT;
            endcase
        endfunction

        function void check_frame(result_t got);
            result_t want;
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected frame tag=%h value=%h crc=%h ok=%b", $time,
                         got.tag_byte, got.value_word, got.received_crc, got.crc_ok);
                mismatches++;
                return;
            end
            want = pending_frames.pop_front();
            if (got.tag_byte !== want.tag_byte)
            begin
                $display("%0t: tag_byte expected %h actual %h", $time,
                         want.tag_byte, got.tag_byte);
                mismatches++;
            end
            if (got.value_word !== want.value_word)
            begin
                $display("%0t: value_word expected %h actual %h", $time,
                         want.value_word, got.value_word);
                mismatches++;
            end
            if (got.received_crc !== want.received_crc)
            begin
                $display("%0t: received_crc expected %h actual %h", $time,
                         want.received_crc, got.received_crc);
                mismatches++;
            end
            if (got.crc_ok !== want.crc_ok)
            begin
                $display("%0t: crc_ok expected %b actual %b", $time,
                         want.crc_ok, got.crc_ok);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  tag_byte;
    logic [31:0] value_word;
    logic [15:0] received_crc;
    logic        crc_ok;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    bit              no_idle;
    int              bytes_sent;
    frame_scoreboard sb = new();

    sync_framed_packet_crc_checker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tag_byte     (tag_byte),
        .value_word   (value_word),
        .received_crc (received_crc),
        .crc_ok       (crc_ok),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // receiver stalls at random, with a chance of about one in five, unless a quiet stretch is running
    always @(negedge clk)
        out_ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 19);

    always @(posedge clk)
    begin : frame_monitor
        result_t got;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got.tag_byte     = tag_byte;
            got.value_word   = value_word;
            got.received_crc = received_crc;
            got.crc_ok       = crc_ok;
            sb.check_frame(got);
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return sb.sync_lead;
            3: return sb.sync_trail;
            default: return 8'($urandom);
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high between back-to-back beats
    task automatic send_byte(input logic [7:0] b);
        if (!no_idle && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < 19);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.absorb_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // let every expected frame out, then cover bytes still in the parse pipeline
    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_frames.size() != 0);
        repeat (6) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // five crc-covered bytes then the crc, little-endian, good or corrupted
    task automatic send_payload(input logic [7:0] body [CRC_SPAN], input bit crc_good);
        logic [15:0] c;
        int          i;
        c = CRC_INIT;
        for (i = 0; i < CRC_SPAN; i++)
            c = frame_scoreboard::crc_update(c, body[i]);
        if (!crc_good)
        begin
            case ($urandom_range(0, 3))
                0: c = 16'hFFFF;
                1: c = 16'h0000;
                default: c = c ^ (16'h0001 << $urandom_range(0, 15));
            endcase
        end
        for (i = 0; i < CRC_SPAN; i++)
            send_byte(body[i]);
        send_byte(c[7:0]);
        send_byte(c[15:8]);
    endtask

    task automatic send_frame();
        logic [7:0] body [CRC_SPAN];
        int         i;
        for (i = 0; i < CRC_SPAN; i++)
            body[i] = pick_byte();
        send_byte(sb.sync_lead);
        send_byte(sb.sync_trail);
        send_payload(body, $urandom_range(0, 99) < 75);
    endtask

    task automatic run_phase(input logic [7:0] lead, input logic [7:0] trail, input bit quiet);
        int start;
        int pick;
        write_reg(REG_SYNC_FIRST, lead);
        write_reg(REG_SYNC_SECOND, trail);
        no_idle = quiet;
        start   = bytes_sent;
        while (bytes_sent - start < 135)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 66)
                send_frame();
            else if (pick < 76)
                repeat ($urandom_range(1, 4)) send_byte(pick_byte());
            else if (pick < 84)
            begin
                // sync start followed by whatever
                send_byte(sb.sync_lead);
                send_byte(pick_byte());
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 3)) send_byte(sb.sync_lead);
                send_frame();
            end
            else if (pick < 96)
            begin
                // lone first sync byte left pending while the stream goes quiet
                send_byte(sb.sync_lead);
                wait_drain();
            end
            else
                wait_drain();
        end
        wait_drain();
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = 8'h00;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_SYNC_FIRST;
        cfg_data   = 8'h00;
        no_idle    = 1'b0;
        bytes_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // a non-sync byte after the first sync drops to hunting; the 55 is then not a sync
        send_byte(8'hAA);
        send_byte(8'h12);
        send_byte(8'h55);
        // repeated first sync, all-ones tag and value, zero crc field
        send_byte(8'hAA);
        send_byte(8'hAA);
        send_byte(8'h55);
        repeat (5) send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        // sync bytes inside the payload are plain data
        send_byte(8'hAA);
        send_byte(8'h55);
        send_payload('{8'h00, 8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b1);
        // pending first sync survives a change of the second sync byte
        send_byte(8'hAA);
        wait_drain();
        write_reg(REG_SYNC_SECOND, 8'hFF);
        send_byte(8'hFF);
        send_payload('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
        wait_drain();

        run_phase(8'hAA, 8'h55, 1'b1);
        run_phase(8'h00, 8'hFF, 1'b0);
        run_phase(8'hFF, 8'h00, 1'b0);
        run_phase(8'h5A, 8'h5A, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 1'b0);

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_frames.size() != 0);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
